>>> sv/svgabw_pkg.sv
// Shared types, register codes and constants for the banked SVGA window register block.
package svgabw_pkg;

	typedef enum logic [1:0] {
		REQ_IO_WR  = 2'd0,
		REQ_IO_RD  = 2'd1,
		REQ_MEM_WR = 2'd2,
		REQ_MEM_RD = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		PC_OTHER,
		PC_MISC_OUT,
		PC_SEQ_IDX,
		PC_SEQ_DATA,
		PC_GDC_IDX,
		PC_GDC_DATA,
		PC_CRTC_IDX,
		PC_CRTC_DATA
	} port_cls_t;

	localparam logic [15:0] PORT_MISC_OUT  = 16'h03C2;
	localparam logic [15:0] PORT_SEQ_IDX   = 16'h03C4;
	localparam logic [15:0] PORT_SEQ_DATA  = 16'h03C5;
	localparam logic [15:0] PORT_GDC_IDX   = 16'h03CE;
	localparam logic [15:0] PORT_GDC_DATA  = 16'h03CF;
	localparam logic [15:0] PORT_CRTC_IDX  = 16'h03D4;
	localparam logic [15:0] PORT_CRTC_DATA = 16'h03D5;
	localparam logic [11:0] PORT_MONO_BLK  = 12'h03B;
	localparam logic [11:0] PORT_COLOR_BLK = 12'h03D;
	localparam logic [15:0] PORT_ALIAS_XOR = 16'h0060;

	localparam logic [4:0] SEQ_KEY       = 5'h06;
	localparam logic [4:0] SEQ_EXT_FIRST = 5'h08;
	localparam logic [4:0] SEQ_BANK_CTRL = 5'h11;
	localparam logic [4:0] SEQ_EXT_LAST  = 5'h12;
	localparam logic [7:0] SEQ_KEY_VALUE = 8'h48;

	localparam logic [3:0] GDC_MODE      = 4'h6;
	localparam logic [3:0] GDC_BANK_A    = 4'h9;
	localparam logic [3:0] GDC_BANK_B    = 4'hA;
	localparam logic [3:0] GDC_MEM_CTRL  = 4'hE;
	localparam logic [3:0] GDC_LOCK      = 4'hF;
	localparam logic [2:0] GDC_KEY_VALUE = 3'd5;

	localparam logic [5:0] CRTC_PROT_LAST = 6'h07;
	localparam logic [5:0] CRTC_TIME_LO   = 6'h0E;
	localparam logic [5:0] CRTC_TIME_HI   = 6'h10;
	localparam logic [5:0] CRTC_VRTC_END  = 6'h11;
	localparam logic [5:0] CRTC_LOCK      = 6'h29;
	localparam logic [5:0] CRTC_EXT_END   = 6'h30;
	localparam logic [5:0] CRTC_ID_FIRST  = 6'h31;
	localparam logic [5:0] CRTC_ID_MODEL0 = 6'h36;
	localparam logic [5:0] CRTC_ID_MODEL1 = 6'h37;
	localparam logic [2:0] CRTC_KEY_VALUE = 3'd5;
	localparam logic [7:0] CRTC_MODEL_ID  = 8'h31;

	localparam logic [7:0]  READ_LOCKED = 8'hFF;
	localparam logic [19:0] BANK_HALF   = 20'h08000;

	localparam int unsigned RAM_AW = 7;

	typedef struct packed {
		req_t       req;
		port_cls_t  cls;
		logic [5:0] idx;
	} dec_t;

	typedef struct packed {
		logic [7:0] seq6;
		logic       seq11_b7;
		logic [1:0] gdc6_win;
		logic [6:0] gdc9;
		logic [6:0] gdca;
		logic       gdce_b3;
		logic       gdce_b0;
		logic [2:0] gdcf_key;
		logic       gdcf_b4;
		logic       crtc11_b7;
		logic       crtc29_b7;
		logic       crtc29_b3;
		logic [2:0] crtc29_key;
		logic       banks_set;
	} shadow_t;

	function automatic logic [RAM_AW-1:0] seq_addr(input logic [4:0] i);
		return {2'b00, i};
	endfunction

	function automatic logic [RAM_AW-1:0] gdc_addr(input logic [3:0] i);
		return {3'b010, i};
	endfunction

	function automatic logic [RAM_AW-1:0] crtc_addr(input logic [5:0] i);
		return {1'b1, i};
	endfunction

	function automatic logic [7:0] reset_value(input logic [RAM_AW-1:0] a);
		logic [7:0] v;
		v = 8'h00;
		if (a[RAM_AW-1]) begin
			unique case (a[5:0])
				6'h31:   v = 8'h57;
				6'h32:   v = 8'h44;
				6'h33:   v = 8'h39;
				6'h34:   v = 8'h30;
				6'h35:   v = 8'h43;
				default: v = 8'h00;
			endcase
		end
		return v;
	endfunction

endpackage

>>> sv/svga_bank_window_register_block_unit.sv
// Top level: banked SVGA memory window with locked extension registers.
// Takes one bus access per clock while in_stall is low and returns one result per access.
// A result passes the register RAM read, then the output register, and is held up only
// while out_stall holds the output register; the output register lets a new access enter
// while a result still waits. Sequencer, graphics and CRTC data registers live
// in a 128x8 register RAM read when the access is taken and written back when the access
// moves to the output register; a write-back to the entry read in that same cycle is
// forwarded. The index registers and the color-select bit are flip-flops in the decoder.
// Every RAM entry carries a valid bit cleared by reset, so no clearing pass is needed after
// reset. The user must write the chip_model register through cfg_we/cfg_wdata only while no
// access is in flight; the block itself does not enforce this.
module svga_bank_window_register_block_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [19:0] bus_address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        forwarded,
	output logic        mem_hit,
	output logic [19:0] linear_address,
	output logic [7:0]  vram_write_data,
	output logic        timing_changed,
	output logic        low_res
);
	import svgabw_pkg::*;

	logic               chip_model_q;
	logic               accept;
	logic               advance;
	dec_t               dec;
	logic [RAM_AW-1:0]  raddr;

	logic               valid_s1;
	dec_t               dec_s1;
	logic [RAM_AW-1:0]  raddr_s1;
	logic [19:0]        addr_s1;
	logic [7:0]         wdata_s1;
	logic [7:0]         rdata_s1;

	shadow_t            sh_q;
	logic [19:0]        base;
	logic               win_hit;

	logic               ram_we;
	logic               wr_ok;
	logic               recompute;
	logic [7:0]         rd_c;
	logic               fwd_c;
	logic               hit_c;
	logic [19:0]        lin_c;
	logic [7:0]         vram_c;
	logic               tc_c;
	logic               low_res_c;
	logic [4:0]         idx5;
	logic [3:0]         idx4;
	logic [5:0]         idx6;

	logic               out_valid_q;
	logic [7:0]         read_data_q;
	logic               forwarded_q;
	logic               mem_hit_q;
	logic [19:0]        linear_address_q;
	logic [7:0]         vram_write_data_q;
	logic               timing_changed_q;
	logic               low_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_model_q <= 1'b0;
		end else if (cfg_we) begin
			chip_model_q <= cfg_wdata;
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	svgabw_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.chip_model (chip_model_q),
		.req_type   (req_type),
		.io_addr    (bus_address[15:0]),
		.wdata      (write_data),
		.dec        (dec),
		.raddr      (raddr)
	);

	svgabw_reg_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.re       (accept),
		.raddr    (raddr),
		.we       (ram_we),
		.waddr    (raddr_s1),
		.wdata    (wdata_s1),
		.rdata_s1 (rdata_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1   <= dec;
			raddr_s1 <= raddr;
			addr_s1  <= bus_address;
			wdata_s1 <= write_data;
		end
	end

	svgabw_bank_map u_bank_map (
		.sh       (sh_q),
		.sel      (addr_s1[16:15]),
		.is_write (dec_s1.req == REQ_MEM_WR),
		.base     (base)
	);

	always_comb begin
		unique case (sh_q.gdc6_win)
			2'd0:    win_hit = addr_s1[19:17] == 3'b101;
			2'd1:    win_hit = addr_s1[19:16] == 4'hA;
			2'd2:    win_hit = addr_s1[19:15] == 5'b10110;
			default: win_hit = addr_s1[19:15] == 5'b10111;
		endcase
	end

	assign idx5 = dec_s1.idx[4:0];
	assign idx4 = dec_s1.idx[3:0];
	assign idx6 = dec_s1.idx;

	always_comb begin
		rd_c      = 8'h00;
		fwd_c     = 1'b0;
		hit_c     = 1'b0;
		lin_c     = 20'h00000;
		vram_c    = 8'h00;
		tc_c      = 1'b0;
		wr_ok     = 1'b0;
		recompute = 1'b0;
		unique case (dec_s1.req)
			REQ_IO_WR: begin
				unique case (dec_s1.cls)
					PC_SEQ_DATA: begin
						if (idx5 >= SEQ_EXT_FIRST) begin
							if (chip_model_q && sh_q.seq6 == SEQ_KEY_VALUE) begin
								wr_ok     = 1'b1;
								recompute = idx5 == SEQ_BANK_CTRL;
							end
						end else begin
							wr_ok = 1'b1;
							fwd_c = 1'b1;
						end
					end
					PC_GDC_DATA: begin
						if (!(idx4 >= GDC_BANK_A && idx4 < GDC_LOCK
								&& sh_q.gdcf_key != GDC_KEY_VALUE)) begin
							wr_ok = 1'b1;
							if (idx4 == GDC_MODE || idx4 == GDC_BANK_A
									|| idx4 == GDC_BANK_B || idx4 == GDC_MEM_CTRL) begin
								recompute = 1'b1;
							end else begin
								fwd_c = 1'b1;
							end
						end
					end
					PC_CRTC_IDX: fwd_c = 1'b0;
					PC_CRTC_DATA: begin
						if (!((idx6 <= CRTC_PROT_LAST && sh_q.crtc11_b7)
								|| (idx6 > CRTC_LOCK && sh_q.crtc29_key != CRTC_KEY_VALUE)
								|| (idx6 >= CRTC_ID_FIRST && idx6 <= CRTC_ID_MODEL1))) begin
							wr_ok = 1'b1;
							fwd_c = 1'b1;
							tc_c  = rdata_s1 != wdata_s1
								&& (idx6 < CRTC_TIME_LO || idx6 > CRTC_TIME_HI);
						end
					end
					default: fwd_c = 1'b1;
				endcase
			end
			REQ_IO_RD: begin
				unique case (dec_s1.cls)
					PC_SEQ_IDX: begin
						rd_c  = {3'b000, idx5};
						fwd_c = 1'b1;
					end
					PC_SEQ_DATA: begin
						if (idx5 >= SEQ_EXT_FIRST) begin
							if (!chip_model_q || sh_q.seq6 != SEQ_KEY_VALUE
									|| idx5 > SEQ_EXT_LAST) begin
								rd_c = READ_LOCKED;
							end else begin
								rd_c = rdata_s1;
							end
						end else begin
							rd_c  = rdata_s1;
							fwd_c = 1'b1;
						end
					end
					PC_GDC_IDX: begin
						rd_c  = {4'h0, idx4};
						fwd_c = 1'b1;
					end
					PC_GDC_DATA: begin
						if (idx4 >= GDC_BANK_A && idx4 < GDC_LOCK && sh_q.gdcf_b4) begin
							rd_c = READ_LOCKED;
						end else begin
							rd_c  = rdata_s1;
							fwd_c = 1'b1;
						end
					end
					PC_CRTC_IDX: rd_c = {2'b00, idx6};
					PC_CRTC_DATA: begin
						if (idx6 > CRTC_LOCK && idx6 < CRTC_EXT_END
								&& !(sh_q.crtc29_b7 && !sh_q.crtc29_b3)) begin
							rd_c = READ_LOCKED;
						end else if (idx6 == CRTC_ID_MODEL0 || idx6 == CRTC_ID_MODEL1) begin
							rd_c = chip_model_q ? CRTC_MODEL_ID : 8'h00;
						end else begin
							rd_c = rdata_s1;
						end
					end
					default: begin
						rd_c  = READ_LOCKED;
						fwd_c = 1'b1;
					end
				endcase
			end
			default: begin
				if (win_hit) begin
					hit_c  = 1'b1;
					lin_c  = {5'b00000, addr_s1[14:0]} + base;
					vram_c = (dec_s1.req == REQ_MEM_WR) ? wdata_s1 : 8'h00;
				end else begin
					fwd_c = 1'b1;
				end
			end
		endcase
	end

	assign ram_we = advance && wr_ok;

	assign low_res_c = (wr_ok && dec_s1.cls == PC_GDC_DATA && idx4 == GDC_MEM_CTRL)
		? !wdata_s1[0] : !sh_q.gdce_b0;

	// mirror the lock and bank control registers for fixed-place reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
		end else if (ram_we) begin
			if (recompute) begin
				sh_q.banks_set <= 1'b1;
			end
			unique case (dec_s1.cls)
				PC_SEQ_DATA: begin
					if (idx5 == SEQ_KEY) begin
						sh_q.seq6 <= wdata_s1;
					end
					if (idx5 == SEQ_BANK_CTRL) begin
						sh_q.seq11_b7 <= wdata_s1[7];
					end
				end
				PC_GDC_DATA: begin
					unique case (idx4)
						GDC_MODE:     sh_q.gdc6_win <= wdata_s1[3:2];
						GDC_BANK_A:   sh_q.gdc9     <= wdata_s1[6:0];
						GDC_BANK_B:   sh_q.gdca     <= wdata_s1[6:0];
						GDC_MEM_CTRL: begin
							sh_q.gdce_b3 <= wdata_s1[3];
							sh_q.gdce_b0 <= wdata_s1[0];
						end
						GDC_LOCK: begin
							sh_q.gdcf_key <= wdata_s1[2:0];
							sh_q.gdcf_b4  <= wdata_s1[4];
						end
						default: ;
					endcase
				end
				PC_CRTC_DATA: begin
					if (idx6 == CRTC_VRTC_END) begin
						sh_q.crtc11_b7 <= wdata_s1[7];
					end
					if (idx6 == CRTC_LOCK) begin
						sh_q.crtc29_b7  <= wdata_s1[7];
						sh_q.crtc29_b3  <= wdata_s1[3];
						sh_q.crtc29_key <= wdata_s1[2:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q       <= rd_c;
			forwarded_q       <= fwd_c;
			mem_hit_q         <= hit_c;
			linear_address_q  <= lin_c;
			vram_write_data_q <= vram_c;
			timing_changed_q  <= tc_c;
			low_res_q         <= low_res_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign read_data       = read_data_q;
	assign forwarded       = forwarded_q;
	assign mem_hit         = mem_hit_q;
	assign linear_address  = linear_address_q;
	assign vram_write_data = vram_write_data_q;
	assign timing_changed  = timing_changed_q;
	assign low_res         = low_res_q;

endmodule

>>> sv/svgabw_decode.sv
// Port decode, plus index registers and color-select bit updated by accepted I/O writes.
module svgabw_decode (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic                             chip_model,
	input  logic [1:0]                       req_type,
	input  logic [15:0]                      io_addr,
	input  logic [7:0]                       wdata,
	output svgabw_pkg::dec_t                 dec,
	output logic [svgabw_pkg::RAM_AW-1:0]    raddr
);
	import svgabw_pkg::*;

	logic [4:0]  seq_index_q;
	logic [3:0]  gdc_index_q;
	logic [5:0]  crtc_index_q;
	logic        color_select_q;
	logic [15:0] port;
	port_cls_t   cls;
	req_t        req;

	assign req = req_t'(req_type);

	always_comb begin
		port = io_addr;
		if ((io_addr[15:4] == PORT_MONO_BLK || io_addr[15:4] == PORT_COLOR_BLK)
				&& !color_select_q) begin
			port = io_addr ^ PORT_ALIAS_XOR;
		end
		unique case (port)
			PORT_MISC_OUT:  cls = PC_MISC_OUT;
			PORT_SEQ_IDX:   cls = PC_SEQ_IDX;
			PORT_SEQ_DATA:  cls = PC_SEQ_DATA;
			PORT_GDC_IDX:   cls = PC_GDC_IDX;
			PORT_GDC_DATA:  cls = PC_GDC_DATA;
			PORT_CRTC_IDX:  cls = PC_CRTC_IDX;
			PORT_CRTC_DATA: cls = PC_CRTC_DATA;
			default:        cls = PC_OTHER;
		endcase
	end

	always_comb begin
		dec.req = req;
		dec.cls = cls;
		unique case (cls)
			PC_SEQ_IDX, PC_SEQ_DATA: begin
				dec.idx = {1'b0, seq_index_q};
				raddr   = seq_addr(seq_index_q);
			end
			PC_GDC_IDX, PC_GDC_DATA: begin
				dec.idx = {2'b00, gdc_index_q};
				raddr   = gdc_addr(gdc_index_q);
			end
			PC_CRTC_IDX, PC_CRTC_DATA: begin
				dec.idx = crtc_index_q;
				raddr   = crtc_addr(crtc_index_q);
			end
			default: begin
				dec.idx = 6'd0;
				raddr   = seq_addr(seq_index_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_index_q    <= '0;
			gdc_index_q    <= '0;
			crtc_index_q   <= '0;
			color_select_q <= 1'b0;
		end else if (accept && req == REQ_IO_WR) begin
			unique case (cls)
				PC_MISC_OUT: color_select_q <= wdata[0];
				PC_SEQ_IDX:  seq_index_q    <= wdata[4:0];
				PC_GDC_IDX:  gdc_index_q    <= wdata[3:0];
				PC_CRTC_IDX: crtc_index_q   <= chip_model ? wdata[5:0] : {1'b0, wdata[4:0]};
				default: ;
			endcase
		end
	end

endmodule

>>> sv/svgabw_reg_ram.sv
// Register file RAM for sequencer, graphics and CRTC data, with entry valid bits and forwarding.
module svgabw_reg_ram (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             re,
	input  logic [svgabw_pkg::RAM_AW-1:0]    raddr,
	input  logic                             we,
	input  logic [svgabw_pkg::RAM_AW-1:0]    waddr,
	input  logic [7:0]                       wdata,
	output logic [7:0]                       rdata_s1
);
	import svgabw_pkg::*;

	localparam int unsigned Depth = 2 ** RAM_AW;

	logic [7:0]       mem_q [Depth];
	logic [Depth-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// forward a write that lands on the entry being read in the same cycle
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && waddr == raddr) begin
				rdata_s1 <= wdata;
			end else if (vld_q[raddr]) begin
				rdata_s1 <= mem_q[raddr];
			end else begin
				rdata_s1 <= reset_value(raddr);
			end
		end
	end

endmodule

>>> sv/svgabw_bank_map.sv
// Bank base selection for memory window accesses from the bank control registers.
module svgabw_bank_map (
	input  svgabw_pkg::shadow_t sh,
	input  logic [1:0]          sel,
	input  logic                is_write,
	output logic [19:0]         base
);
	import svgabw_pkg::*;

	logic [19:0] b9;
	logic [19:0] ba;
	logic [19:0] hi;
	logic [19:0] lo_pick;
	logic [19:0] hi_pick;

	assign b9 = {1'b0, sh.gdc9, 12'h000};
	assign ba = {1'b0, sh.gdca, 12'h000};
	assign hi = sh.gdc6_win[1] ? 20'h00000 : BANK_HALF;

	always_comb begin
		lo_pick = b9;
		hi_pick = b9;
		priority if (sh.seq11_b7) begin
			lo_pick = is_write ? ba : b9;
			hi_pick = is_write ? ba : b9;
		end else if (sh.gdce_b3) begin
			if (sh.gdc6_win != 2'b00) begin
				lo_pick = ba;
				hi_pick = b9;
			end else begin
				lo_pick = sel[1] ? b9 : ba;
				hi_pick = sel[1] ? b9 : ba;
			end
		end else begin
			lo_pick = b9;
			hi_pick = b9;
		end
		if (!sh.banks_set) begin
			base = 20'h00000;
		end else if (sel[0]) begin
			base = hi_pick + hi;
		end else begin
			base = lo_pick;
		end
	end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the banked SVGA window register block: queued bus accesses, checked results.
`timescale 1ns / 1ps

module testbench;
	import svgabw_pkg::*;

	localparam int unsigned PHASE_ITEMS = 450;
	localparam int unsigned IDLE_LIMIT  = 4000;

	typedef struct {
		req_t        kind;
		logic [19:0] addr;
		logic [7:0]  data;
	} bus_access_t;

	typedef struct {
		logic [7:0]  read_data;
		logic        forwarded;
		logic        mem_hit;
		logic [19:0] linear_address;
		logic [7:0]  vram_write_data;
		logic        timing_changed;
		logic        low_res;
	} bus_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = 2'b00;
	logic [19:0] bus_address = 20'h00000;
	logic [7:0]  write_data = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  read_data;
	logic        forwarded;
	logic        mem_hit;
	logic [19:0] linear_address;
	logic [7:0]  vram_write_data;
	logic        timing_changed;
	logic        low_res;

	bus_access_t access_queue [$];
	bus_result_t due_results [$];

	bit          plan_color;
	int unsigned phase_items;
	int unsigned fail_count;
	int unsigned idle_cycles;
	bit          in_taken;
	int unsigned in_gap;
	bit          in_calm;
	int unsigned stall_left;
	bit          out_calm;

	// shadow of the block state
	bit          model;
	logic [4:0]  seq_idx;
	logic [3:0]  gdc_idx;
	logic [5:0]  crtc_idx;
	logic        color_sel;
	logic [7:0]  seq_regs [32];
	logic [7:0]  gdc_regs [16];
	logic [7:0]  crtc_regs [64];
	logic [19:0] rd_bank [4];
	logic [19:0] wr_bank [4];

	svga_bank_window_register_block_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.bus_address(bus_address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.forwarded(forwarded),
		.mem_hit(mem_hit),
		.linear_address(linear_address),
		.vram_write_data(vram_write_data),
		.timing_changed(timing_changed),
		.low_res(low_res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic clear_shadow();
		model = 1'b0;
		seq_idx = '0;
		gdc_idx = '0;
		crtc_idx = '0;
		color_sel = 1'b0;
		for (int i = 0; i < 32; i++) seq_regs[i] = 8'h00;
		for (int i = 0; i < 16; i++) gdc_regs[i] = 8'h00;
		for (int i = 0; i < 64; i++) crtc_regs[i] = 8'h00;
		crtc_regs[CRTC_ID_FIRST]     = 8'h57;
		crtc_regs[CRTC_ID_FIRST + 1] = 8'h44;
		crtc_regs[CRTC_ID_FIRST + 2] = 8'h39;
		crtc_regs[CRTC_ID_FIRST + 3] = 8'h30;
		crtc_regs[CRTC_ID_FIRST + 4] = 8'h43;
		for (int i = 0; i < 4; i++) begin
			rd_bank[i] = '0;
			wr_bank[i] = '0;
		end
	endtask

	task automatic rebuild_banks();
		logic [19:0] b9, ba, hi;
		b9 = {1'b0, gdc_regs[GDC_BANK_A][6:0], 12'h000};
		ba = {1'b0, gdc_regs[GDC_BANK_B][6:0], 12'h000};
		hi = gdc_regs[GDC_MODE][3] ? 20'h00000 : BANK_HALF;
		if (seq_regs[SEQ_BANK_CTRL][7]) begin
			rd_bank = '{b9, b9 + hi, b9, b9 + hi};
			wr_bank = '{ba, ba + hi, ba, ba + hi};
		end else if (gdc_regs[GDC_MEM_CTRL][3]) begin
			if (gdc_regs[GDC_MODE][3:2] != 2'b00)
				rd_bank = '{ba, b9 + hi, ba, b9 + hi};
			else
				rd_bank = '{ba, ba + hi, b9, b9 + hi};
			wr_bank = rd_bank;
		end else begin
			rd_bank = '{b9, b9 + hi, b9, b9 + hi};
			wr_bank = rd_bank;
		end
	endtask

	function automatic bit in_window(input logic [19:0] a);
		case (gdc_regs[GDC_MODE][3:2])
			2'd0:    return a >= 20'ha0000 && a < 20'hc0000;
			2'd1:    return a >= 20'ha0000 && a < 20'hb0000;
			2'd2:    return a >= 20'hb0000 && a < 20'hb8000;
			default: return a >= 20'hb8000 && a < 20'hc0000;
		endcase
	endfunction

	task automatic predict_bus_result(input req_t kind, input logic [19:0] addr,
			input logic [7:0] d);
		bus_result_t r;
		logic [15:0] port;
		logic [5:0]  ci;
		logic [7:0]  old;
		logic [19:0] base;
		bit          gdc_ext;
		r = '{default: '0};
		port = addr[15:0];
		if ((port[15:4] == PORT_MONO_BLK || port[15:4] == PORT_COLOR_BLK) && !color_sel)
			port = port ^ PORT_ALIAS_XOR;
		ci = crtc_idx;
		gdc_ext = gdc_idx >= GDC_BANK_A && gdc_idx < GDC_LOCK;
		case (kind)
			REQ_IO_WR: begin
				r.forwarded = 1'b1;
				case (port)
					PORT_MISC_OUT: color_sel = d[0];
					PORT_SEQ_IDX:  seq_idx = d[4:0];
					PORT_SEQ_DATA: begin
						if (seq_idx >= SEQ_EXT_FIRST) begin
							r.forwarded = 1'b0;
							if (model && seq_regs[SEQ_KEY] == SEQ_KEY_VALUE) begin
								seq_regs[seq_idx] = d;
								if (seq_idx == SEQ_BANK_CTRL) rebuild_banks();
							end
						end else begin
							seq_regs[seq_idx] = d;
						end
					end
					PORT_GDC_IDX: gdc_idx = d[3:0];
					PORT_GDC_DATA: begin
						if (gdc_ext && gdc_regs[GDC_LOCK][2:0] != GDC_KEY_VALUE) begin
							r.forwarded = 1'b0;
						end else begin
							gdc_regs[gdc_idx] = d;
							if (gdc_idx == GDC_MODE || gdc_idx == GDC_BANK_A ||
									gdc_idx == GDC_BANK_B || gdc_idx == GDC_MEM_CTRL) begin
								r.forwarded = 1'b0;
								rebuild_banks();
							end
						end
					end
					PORT_CRTC_IDX: begin
						r.forwarded = 1'b0;
						crtc_idx = model ? d[5:0] : {1'b0, d[4:0]};
					end
					PORT_CRTC_DATA: begin
						if ((ci <= CRTC_PROT_LAST && crtc_regs[CRTC_VRTC_END][7]) ||
								(ci > CRTC_LOCK && crtc_regs[CRTC_LOCK][2:0] != CRTC_KEY_VALUE) ||
								(ci >= CRTC_ID_FIRST && ci <= CRTC_ID_MODEL1)) begin
							r.forwarded = 1'b0;
						end else begin
							old = crtc_regs[ci];
							crtc_regs[ci] = d;
							if (old != d && (ci < CRTC_TIME_LO || ci > CRTC_TIME_HI))
								r.timing_changed = 1'b1;
						end
					end
					default: ;
				endcase
			end
			REQ_IO_RD: begin
				r.forwarded = 1'b1;
				case (port)
					PORT_SEQ_IDX: r.read_data = {3'b000, seq_idx};
					PORT_SEQ_DATA: begin
						if (seq_idx >= SEQ_EXT_FIRST) begin
							r.forwarded = 1'b0;
							if (!model || seq_regs[SEQ_KEY] != SEQ_KEY_VALUE ||
									seq_idx > SEQ_EXT_LAST)
								r.read_data = READ_LOCKED;
							else
								r.read_data = seq_regs[seq_idx];
						end else begin
							r.read_data = seq_regs[seq_idx];
						end
					end
					PORT_GDC_IDX: r.read_data = {4'h0, gdc_idx};
					PORT_GDC_DATA: begin
						if (gdc_ext && gdc_regs[GDC_LOCK][4]) begin
							r.forwarded = 1'b0;
							r.read_data = READ_LOCKED;
						end else begin
							r.read_data = gdc_regs[gdc_idx];
						end
					end
					PORT_CRTC_IDX: begin
						r.forwarded = 1'b0;
						r.read_data = {2'b00, ci};
					end
					PORT_CRTC_DATA: begin
						r.forwarded = 1'b0;
						if (ci > CRTC_LOCK && ci < CRTC_EXT_END &&
								{crtc_regs[CRTC_LOCK][7], crtc_regs[CRTC_LOCK][3]} != 2'b10)
							r.read_data = READ_LOCKED;
						else if (ci == CRTC_ID_MODEL0 || ci == CRTC_ID_MODEL1)
							r.read_data = model ? CRTC_MODEL_ID : 8'h00;
						else
							r.read_data = crtc_regs[ci];
					end
					default: r.read_data = READ_LOCKED;
				endcase
			end
			default: begin
				if (in_window(addr)) begin
					base = (kind == REQ_MEM_WR) ? wr_bank[addr[16:15]] : rd_bank[addr[16:15]];
					r.mem_hit = 1'b1;
					r.linear_address = {5'b00000, addr[14:0]} + base;
					if (kind == REQ_MEM_WR) r.vram_write_data = d;
				end else begin
					r.forwarded = 1'b1;
				end
			end
		endcase
		r.low_res = !gdc_regs[GDC_MEM_CTRL][0];
		due_results.push_back(r);
	endtask

	task automatic queue_access(input req_t kind, input logic [19:0] addr, input logic [7:0] d);
		if (kind == REQ_IO_WR && addr[15:0] == PORT_MISC_OUT) plan_color = d[0];
		access_queue.push_back('{kind: kind, addr: addr, data: d});
		phase_items++;
	endtask

	task automatic queue_io(input req_t kind, input logic [15:0] port, input logic [7:0] d);
		logic [3:0] hi;
		hi = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
		queue_access(kind, {hi, port}, d);
	endtask

	task automatic queue_data(input logic [15:0] port);
		int unsigned n;
		n = $urandom_range(1, 3);
		repeat (n) begin
			if ($urandom_range(0, 1) != 0) queue_io(REQ_IO_WR, port, 8'($urandom));
			else queue_io(REQ_IO_RD, port, 8'($urandom));
		end
	endtask

	function automatic logic [15:0] crtc_port(input bit is_data);
		logic [15:0] p;
		p = is_data ? PORT_CRTC_DATA : PORT_CRTC_IDX;
		if (!plan_color ^ ($urandom_range(0, 9) == 0)) p = p ^ PORT_ALIAS_XOR;
		return p;
	endfunction

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_directed();
		queue_access(REQ_IO_RD, {4'h0, PORT_MISC_OUT}, 8'h00);
		queue_access(REQ_IO_WR, {4'h0, PORT_MISC_OUT}, 8'h01);
		queue_access(REQ_IO_WR, {4'hf, PORT_CRTC_IDX}, 8'hff);
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_IDX}, {2'b00, CRTC_ID_MODEL0});
		queue_access(REQ_IO_RD, {4'h0, PORT_CRTC_DATA}, 8'h00);
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_IDX}, {2'b00, CRTC_LOCK});
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_DATA}, 8'h85);
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_IDX}, 8'h2a);
		queue_access(REQ_IO_RD, {4'h0, PORT_CRTC_DATA}, 8'h00);
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_DATA}, 8'hff);
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_IDX}, {2'b00, CRTC_VRTC_END});
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_DATA}, 8'h80);
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_IDX}, 8'h00);
		queue_access(REQ_IO_WR, {4'h0, PORT_CRTC_DATA}, 8'h55);
		queue_access(REQ_IO_WR, {4'h0, PORT_SEQ_IDX}, {3'b000, SEQ_KEY});
		queue_access(REQ_IO_WR, {4'h0, PORT_SEQ_DATA}, SEQ_KEY_VALUE);
		queue_access(REQ_IO_WR, {4'h0, PORT_SEQ_IDX}, {3'b000, SEQ_BANK_CTRL});
		queue_access(REQ_IO_WR, {4'h0, PORT_SEQ_DATA}, 8'h80);
		queue_access(REQ_IO_RD, {4'h0, PORT_SEQ_DATA}, 8'h00);
		queue_access(REQ_IO_WR, {4'h0, PORT_GDC_IDX}, {4'h0, GDC_LOCK});
		queue_access(REQ_IO_WR, {4'h0, PORT_GDC_DATA}, 8'h05);
		queue_access(REQ_IO_WR, {4'h0, PORT_GDC_IDX}, {4'h0, GDC_BANK_A});
		queue_access(REQ_IO_WR, {4'h0, PORT_GDC_DATA}, 8'hff);
		queue_access(REQ_MEM_WR, 20'hbffff, 8'hff);
		queue_access(REQ_MEM_RD, 20'ha0000, 8'h00);
		queue_access(REQ_MEM_RD, 20'h9ffff, 8'h00);
		queue_access(REQ_IO_WR, {4'h0, PORT_MISC_OUT}, 8'h00);
	endtask

	task automatic queue_burst();
		int unsigned pick, n;
		logic [7:0]  v;
		logic [15:0] port;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			case ($urandom_range(0, 2))
				0: begin
					queue_io(REQ_IO_WR, PORT_SEQ_IDX, {3'b000, SEQ_KEY});
					v = ($urandom_range(0, 4) != 0) ? SEQ_KEY_VALUE : 8'($urandom);
					queue_io(REQ_IO_WR, PORT_SEQ_DATA, v);
				end
				1: begin
					queue_io(REQ_IO_WR, PORT_GDC_IDX, {4'h0, GDC_LOCK});
					v = ($urandom_range(0, 3) != 0) ? {5'($urandom), GDC_KEY_VALUE}
						: 8'($urandom);
					queue_io(REQ_IO_WR, PORT_GDC_DATA, v);
				end
				default: begin
					queue_io(REQ_IO_WR, crtc_port(1'b0), {2'b00, CRTC_LOCK});
					v = ($urandom_range(0, 3) != 0) ? {1'b1, 3'($urandom), 1'b0, CRTC_KEY_VALUE}
						: 8'($urandom);
					queue_io(REQ_IO_WR, crtc_port(1'b1), v);
				end
			endcase
		end else if (pick < 30) begin
			v = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8'h12)) : 8'($urandom);
			queue_io(REQ_IO_WR, PORT_SEQ_IDX, v);
			if ($urandom_range(0, 4) == 0) queue_io(REQ_IO_RD, PORT_SEQ_IDX, 8'($urandom));
			queue_data(PORT_SEQ_DATA);
		end else if (pick < 50) begin
			queue_io(REQ_IO_WR, PORT_GDC_IDX, 8'($urandom));
			if ($urandom_range(0, 4) == 0) queue_io(REQ_IO_RD, PORT_GDC_IDX, 8'($urandom));
			queue_data(PORT_GDC_DATA);
		end else if (pick < 70) begin
			case ($urandom_range(0, 5))
				0:       v = {2'b00, CRTC_LOCK};
				1:       v = {2'b00, CRTC_VRTC_END};
				2:       v = 8'($urandom_range(8'h2a, 8'h2f));
				3:       v = 8'($urandom_range(8'h30, 8'h37));
				default: v = 8'($urandom);
			endcase
			queue_io(REQ_IO_WR, crtc_port(1'b0), v);
			if ($urandom_range(0, 4) == 0) queue_io(REQ_IO_RD, crtc_port(1'b0), 8'($urandom));
			port = crtc_port(1'b1);
			queue_data(port);
		end else if (pick < 90) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				if ($urandom_range(0, 9) < 8)
					v = 8'($urandom);
				if ($urandom_range(0, 9) < 8) begin
					if ($urandom_range(0, 1) != 0)
						queue_access(REQ_MEM_WR, 20'($urandom_range(20'ha0000, 20'hbffff)), 8'($urandom));
					else
						queue_access(REQ_MEM_RD, 20'($urandom_range(20'ha0000, 20'hbffff)), 8'($urandom));
				end else begin
					if ($urandom_range(0, 1) != 0)
						queue_access(REQ_MEM_WR, 20'($urandom), 8'($urandom));
					else
						queue_access(REQ_MEM_RD, 20'($urandom), 8'($urandom));
				end
			end
		end else if (pick < 95) begin
			queue_io(REQ_IO_WR, PORT_MISC_OUT, 8'($urandom));
		end else if ($urandom_range(0, 1) != 0) begin
			queue_access(req_t'($urandom_range(0, 3)), 20'($urandom), 8'($urandom));
		end else begin
			queue_access(req_t'($urandom_range(0, 3)),
				{4'($urandom), 16'($urandom_range(16'h03b0, 16'h03df))}, 8'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (access_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_model(input bit value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		model = value;
	endtask

	initial begin
		int ph;
		clear_shadow();
		plan_color = 1'b0;
		fail_count = 0;
		in_calm = 1'b0;
		out_calm = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (ph = 0; ph < 4; ph++) begin
			wait_drained();
			write_model(!ph[0]);
			phase_items = 0;
			if (ph == 0) queue_directed();
			while (phase_items < PHASE_ITEMS) queue_burst();
		end
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// driver: sample transfer at the rising edge, advance at the falling edge
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) predict_bus_result(req_t'(req_type), bus_address, write_data);
	end

	always @(negedge clk) begin
		bus_access_t cur;
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (access_queue.size() != 0) begin
				cur = access_queue.pop_front();
				req_type <= cur.kind;
				bus_address <= cur.addr;
				write_data <= cur.data;
				in_valid <= 1'b1;
				in_gap = pick_gap(in_calm);
				if ($urandom_range(0, 99) == 0) in_calm = !in_calm;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap(out_calm);
				if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bus_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result transfer with no access outstanding");
				fail_count++;
			end else begin
				e = due_results.pop_front();
				if (read_data !== e.read_data) begin
					$error("read_data expected %h actual %h", e.read_data, read_data);
					fail_count++;
				end
				if (forwarded !== e.forwarded) begin
					$error("forwarded expected %b actual %b", e.forwarded, forwarded);
					fail_count++;
				end
				if (mem_hit !== e.mem_hit) begin
					$error("mem_hit expected %b actual %b", e.mem_hit, mem_hit);
					fail_count++;
				end
				if (linear_address !== e.linear_address) begin
					$error("linear_address expected %h actual %h", e.linear_address,
						linear_address);
					fail_count++;
				end
				if (vram_write_data !== e.vram_write_data) begin
					$error("vram_write_data expected %h actual %h", e.vram_write_data,
						vram_write_data);
					fail_count++;
				end
				if (timing_changed !== e.timing_changed) begin
					$error("timing_changed expected %b actual %b", e.timing_changed,
						timing_changed);
					fail_count++;
				end
				if (low_res !== e.low_res) begin
					$error("low_res expected %b actual %b", e.low_res, low_res);
					fail_count++;
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
